### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/srrs_pkg.sv
// ----------------------------------------------------------------------------
// srrs_pkg
// Constants, control store types and microcode for the skip-region splitter.
// ----------------------------------------------------------------------------
package srrs_pkg;

    localparam int SKIP_SLOTS  = 4;
    localparam int MAX_CHUNKS  = SKIP_SLOTS + 1;
    localparam int TABLE_SLOTS = 4;
    localparam int TBL_W       = 2;
    localparam int SLOT_W      = (SKIP_SLOTS > 1) ? $clog2(SKIP_SLOTS) : 1;
    localparam int CHUNK_W     = $clog2(MAX_CHUNKS);
    localparam int CFG_IDX_W   = 3;
    localparam int ADDR_W      = 32;
    localparam int OFF_W       = 33;
    localparam int SUM_W       = 34;
    localparam int CUR_W       = 35;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 72;

    localparam logic [ADDR_W-1:0] UNUSED_OFFSET = '1;

    // Low bit of a configuration index picks the register kind in a slot.
    localparam logic KIND_OFFSET = 1'b0;
    localparam logic KIND_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_PHYS,
        ST_SCAN,
        ST_TAKE,
        ST_EMIT
    } step_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CLIP,
        OP_PHYS,
        OP_SCAN,
        OP_TAKE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    typedef enum logic [1:0] {
        BR_NEVER,
        BR_SCAN_MORE,
        BR_MORE_CHUNKS
    } br_t;

    typedef struct packed {
        op_t   op;
        wait_t wait_on;
        br_t   br;
        step_t jump;
        step_t next;
    } ctrl_word_t;

    // Control store: one word per step.
    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t w;
        unique case (s)
            ST_IDLE: w = '{OP_LOAD, WAIT_IN,   BR_NEVER,       ST_IDLE, ST_CLIP};
            ST_CLIP: w = '{OP_CLIP, WAIT_NONE, BR_NEVER,       ST_IDLE, ST_PHYS};
            ST_PHYS: w = '{OP_PHYS, WAIT_NONE, BR_NEVER,       ST_IDLE, ST_SCAN};
            ST_SCAN: w = '{OP_SCAN, WAIT_NONE, BR_SCAN_MORE,   ST_SCAN, ST_TAKE};
            ST_TAKE: w = '{OP_TAKE, WAIT_NONE, BR_NEVER,       ST_IDLE, ST_EMIT};
            ST_EMIT: w = '{OP_EMIT, WAIT_OUT,  BR_MORE_CHUNKS, ST_PHYS, ST_IDLE};
            default: w = '{OP_LOAD, WAIT_IN,   BR_NEVER,       ST_IDLE, ST_CLIP};
        endcase
        return w;
    endfunction

endpackage

### rtl/srrs_skip_table.sv
// ----------------------------------------------------------------------------
// srrs_skip_table
// Skip area registers with a write port and one slot-addressed read port.
// ----------------------------------------------------------------------------
module srrs_skip_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srrs_pkg::ADDR_W-1:0]   cfg_data,
    input  logic [srrs_pkg::SLOT_W-1:0]   rd_slot,
    output logic [srrs_pkg::ADDR_W-1:0]   rd_offset,
    output logic [srrs_pkg::ADDR_W-1:0]   rd_length
);
    import srrs_pkg::*;

    logic [ADDR_W-1:0] off_reg [TABLE_SLOTS];
    logic [ADDR_W-1:0] len_reg [TABLE_SLOTS];
    logic [TBL_W-1:0]  wr_slot;
    logic [TBL_W-1:0]  rd_idx;

    assign wr_slot = cfg_index[CFG_IDX_W-1:1];
    assign rd_idx  = TBL_W'(rd_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                off_reg[i] <= UNUSED_OFFSET;
                len_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[0] == KIND_OFFSET)
                off_reg[wr_slot] <= cfg_data;
            else if (cfg_index[0] == KIND_LENGTH)
                len_reg[wr_slot] <= cfg_data;
        end
    end

    assign rd_offset = off_reg[rd_idx];
    assign rd_length = len_reg[rd_idx];

endmodule

### rtl/skip_region_read_splitter_top.sv
// ----------------------------------------------------------------------------
// skip_region_read_splitter_top
// Splits a logical region read into physical chunks around skipped areas.
// ----------------------------------------------------------------------------
// One read request (region base, region size, read position, byte count)
// comes in as a single transfer and leaves as one to five chunk transfers,
// each giving the physical offset from the region base with skipped bytes
// counted in, the contiguous length to read there, and tlast on the final
// chunk. The count is first clipped to what is left in the region; a request
// with nothing left gives one zero-length chunk marked last. A small control
// store sequences the datapath: each request is accepted and then clipped,
// and each chunk takes a physical-position step, a scan of one to four skip
// slots, a take step and an emit step. A slot cuts at most one chunk of a
// request, and cuts come in slot order. The skip-table scan runs one slot
// per cycle through the shared comparator. Chunk results sit in an output
// register, so a stalled consumer only holds the sequencer when a further
// chunk is ready, and the next request is taken while the last chunk still
// waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skip_region_read_splitter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request: region_base, region_size, read_position, request_bytes.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [srrs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Chunk: chunk_offset, chunk_bytes, then zero padding.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [srrs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    // Skip table writes: index 2N is skipN_offset, 2N+1 is skipN_length.
    input  logic                              cfg_we,
    input  logic [srrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srrs_pkg::ADDR_W-1:0]       cfg_data
);
    import srrs_pkg::*;

    // Sequencer.
    step_t      step_reg, step_next;
    ctrl_word_t word;
    logic       go;
    logic       take_branch;

    // Request and scan state.
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]  left_reg, left_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CUR_W-1:0]   cur_reg, cur_next;
    logic [ADDR_W-1:0]  room_reg, room_next;
    logic [ADDR_W-1:0]  take_reg, take_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [CHUNK_W-1:0] chunk_cnt_reg, chunk_cnt_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]  out_offset_reg, out_offset_next;
    logic [ADDR_W-1:0] out_bytes_reg, out_bytes_next;
    logic              out_last_reg, out_last_next;
    logic              out_free;

    // Skip table read.
    logic [ADDR_W-1:0] skip_offset;
    logic [ADDR_W-1:0] skip_length;

    // Datapath terms.
    logic [CUR_W-1:0]  skip_offset_ext;
    logic              slot_unused;
    logic              slot_cuts;
    logic              slot_is_last;
    logic              scan_stop;
    logic [ADDR_W:0]   pos_plus_req;
    logic [SUM_W-1:0]  offset_full;
    logic [ADDR_W-1:0] left_after;
    logic              emit_last;

    srrs_skip_table u_skip_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_slot   (slot_reg),
        .rd_offset (skip_offset),
        .rd_length (skip_length)
    );

    assign word     = ucode(step_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    // A slot stops the scan when it is unused, when it starts beyond the
    // current physical position (it cuts the chunk), or when it is the last.
    assign skip_offset_ext = CUR_W'(skip_offset);
    assign slot_unused     = (skip_offset == UNUSED_OFFSET);
    assign slot_cuts       = (cur_reg < skip_offset_ext);
    assign slot_is_last    = (slot_reg == SLOT_W'(SKIP_SLOTS - 1));
    assign scan_stop       = slot_unused || slot_cuts || slot_is_last;

    assign pos_plus_req = {1'b0, pos_reg} + {1'b0, left_reg};
    assign offset_full  = SUM_W'(pos_reg) + sum_reg;
    assign left_after   = left_reg - take_reg;
    assign emit_last    = (left_after == '0) ||
                          (chunk_cnt_reg == CHUNK_W'(MAX_CHUNKS - 1));

    // Step sequencing: hold while the word's wait condition is unmet.
    always_comb
    begin
        unique case (word.wait_on)
            WAIT_IN:  go = s_axis_tvalid;
            WAIT_OUT: go = out_free;
            default:  go = 1'b1;
        endcase

        unique case (word.br)
            BR_SCAN_MORE:   take_branch = !scan_stop;
            BR_MORE_CHUNKS: take_branch = !emit_last;
            default:        take_branch = 1'b0;
        endcase

        if (!go)
            step_next = step_reg;
        else if (take_branch)
            step_next = word.jump;
        else
            step_next = word.next;
    end

    // Datapath controlled by the current control word.
    always_comb
    begin
        base_next       = base_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        sum_next        = sum_reg;
        cur_next        = cur_reg;
        room_next       = room_reg;
        take_next       = take_reg;
        slot_next       = slot_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_offset_next = out_offset_reg;
        out_bytes_next  = out_bytes_reg;
        out_last_next   = out_last_reg;

        if (go)
        begin
            unique case (word.op)
                OP_LOAD:
                begin
                    base_next      = s_axis_tdata[31:0];
                    size_next      = s_axis_tdata[63:32];
                    pos_next       = s_axis_tdata[95:64];
                    left_next      = s_axis_tdata[127:96];
                    chunk_cnt_next = '0;
                end
                OP_CLIP:
                begin
                    if (pos_reg >= size_reg)
                        left_next = '0;
                    else if (pos_plus_req > {1'b0, size_reg})
                        left_next = size_reg - pos_reg;
                end
                OP_PHYS:
                begin
                    cur_next  = CUR_W'(base_reg) + CUR_W'(pos_reg);
                    sum_next  = '0;
                    room_next = '0;
                    slot_next = '0;
                end
                OP_SCAN:
                begin
                    if (slot_unused)
                    begin
                        room_next = room_reg;
                    end
                    else if (slot_cuts)
                    begin
                        room_next = ADDR_W'(skip_offset_ext - cur_reg);
                    end
                    else
                    begin
                        sum_next = sum_reg + SUM_W'(skip_length);
                        cur_next = cur_reg + CUR_W'(skip_length);
                        if (!slot_is_last)
                            slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                OP_TAKE:
                begin
                    if ((room_reg != '0) && (left_reg > room_reg))
                        take_next = room_reg;
                    else
                        take_next = left_reg;
                end
                OP_EMIT:
                begin
                    out_valid_next  = 1'b1;
                    out_offset_next = offset_full[OFF_W-1:0];
                    out_bytes_next  = take_reg;
                    out_last_next   = emit_last;
                    pos_next        = pos_reg + take_reg;
                    left_next       = left_after;
                    chunk_cnt_next  = chunk_cnt_reg + CHUNK_W'(1);
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            out_valid_reg <= 1'b0;
            chunk_cnt_reg <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            chunk_cnt_reg <= chunk_cnt_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        size_reg       <= size_next;
        pos_reg        <= pos_next;
        left_reg       <= left_next;
        sum_reg        <= sum_next;
        cur_reg        <= cur_next;
        room_reg       <= room_next;
        take_reg       <= take_next;
        out_offset_reg <= out_offset_next;
        out_bytes_reg  <= out_bytes_next;
        out_last_reg   <= out_last_next;
    end

    // Port outputs.
    always_comb
    begin
        s_axis_tready = (word.wait_on == WAIT_IN);
        m_axis_tvalid = out_valid_reg;
        m_axis_tlast  = out_last_reg;
        m_axis_tdata  = {{(OUT_TDATA_W - OFF_W - ADDR_W){1'b0}}, out_bytes_reg, out_offset_reg};
    end

    // A chunk never asks for more bytes than the request still has.
    `ASSERT_IMPLY(a_take_within_left, step_reg == ST_EMIT, take_reg <= left_reg,
        "chunk length exceeds remaining request bytes")

    // No request produces more chunks than the table allows.
    `ASSERT_IMPLY(a_chunk_bound, step_reg == ST_EMIT,
        chunk_cnt_reg <= CHUNK_W'(MAX_CHUNKS - 1), "too many chunks for one request")

    // A ready chunk waits while the previous one is still held downstream.
    `ASSERT_NEXT(a_emit_holds, (step_reg == ST_EMIT) && m_axis_tvalid && !m_axis_tready,
        step_reg == ST_EMIT, "chunk emitted over a stalled output")

endmodule
